### hw/rtl/per_rank_load_summary_macros.svh
// Assertion macros for the per-rank load summary checker.
`ifndef PER_RANK_LOAD_SUMMARY_MACROS_SVH
`define PER_RANK_LOAD_SUMMARY_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PRLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PRLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/prls_pkg.sv
// Shared widths and controller/datapath interface types for the load summary.
`timescale 1ns / 1ps
package prls_pkg;

  localparam int COST_W    = 32;
  localparam int RANK_W    = 6;
  localparam int CNT_W     = 7;
  localparam int TOT_W     = 40;
  localparam int GT_W      = 46;
  localparam int DIV_CNT_W = $clog2(GT_W);

  typedef struct packed {
    logic accept;
    logic upd;
    logic gadd;
    logic div_start;
    logic emit_rd;
    logic emit_load;
    logic emit_next;
    logic clear;
  } prls_cmd_t;

  typedef struct packed {
    logic last_item;
    logic div_done;
    logic out_taken;
    logic emit_last;
  } prls_stat_t;

endpackage

### hw/rtl/prls_div.sv
// Restoring divider, one quotient bit per cycle: grand total over rank count.
`timescale 1ns / 1ps
module prls_div
  import prls_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [GT_W-1:0]  dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [GT_W-1:0]  quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [GT_W-1:0]      dq_r, dq_nxt;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       dvs_ext;
  logic                 ge;

  assign trial   = {rem_r, dq_r[GT_W-1]};
  assign dvs_ext = {1'b0, divisor};
  assign ge      = (trial >= dvs_ext);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(GT_W - 1);
      rem_nxt  = '0;
      dq_nxt   = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? CNT_W'(trial - dvs_ext) : trial[CNT_W-1:0];
      dq_nxt  = {dq_r[GT_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

### hw/rtl/prls_dp.sv
// Datapath: rank total memory, running total and max, divider, result register.
`timescale 1ns / 1ps
module prls_dp
  import prls_pkg::*;
#(
  parameter int MAX_RANKS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  prls_cmd_t         cmd,
  output prls_stat_t        stat,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic [COST_W-1:0] in_block_cost,
  input  logic [RANK_W-1:0] in_rank_id,
  input  logic              in_last_block,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RANK_W-1:0] out_rank_index,
  output logic [TOT_W-1:0]  out_rank_time,
  output logic [TOT_W-1:0]  out_max_time,
  output logic [TOT_W-1:0]  out_average_time,
  output logic              out_bad_rank_seen,
  output logic              out_last_result
);

  localparam int RANK_LIMIT = (MAX_RANKS < 64) ? MAX_RANKS : 64;
  localparam int AW         = (RANK_LIMIT > 1) ? $clog2(RANK_LIMIT) : 1;
  localparam int MEM_D      = 1 << AW;

  logic [TOT_W-1:0]  mem [MEM_D];
  logic [MEM_D-1:0]  vld_r;
  logic [TOT_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_addr;

  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [COST_W-1:0] cost_r;
  logic [RANK_W-1:0] rank_r;
  logic              last_r;
  logic [AW-1:0]     k_r;
  logic [GT_W-1:0]   grand_r;
  logic [TOT_W-1:0]  largest_r;
  logic              flag_r;
  logic [TOT_W-1:0]  delta_r;

  logic [TOT_W-1:0]  old_val;
  logic [TOT_W:0]    sum_raw;
  logic [TOT_W-1:0]  sum_sat;
  logic [TOT_W-1:0]  headroom;
  logic [TOT_W-1:0]  cost_ext;
  logic              bad;
  logic [GT_W:0]     gsum;
  logic              emit_last;
  logic [GT_W-1:0]   quotient;
  logic              div_done;

  logic              out_valid_r;
  logic [RANK_W-1:0] out_idx_r;
  logic [TOT_W-1:0]  out_time_r;
  logic [TOT_W-1:0]  out_max_r;
  logic [TOT_W-1:0]  out_avg_r;
  logic              out_bad_r;
  logic              out_last_r;

  always_comb begin
    n_nxt = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      n_nxt = CNT_W'(1);
    end else if (cfg_wr_data > CNT_W'(RANK_LIMIT)) begin
      n_nxt = CNT_W'(RANK_LIMIT);
    end
  end

  assign rd_addr  = cmd.emit_rd ? k_r : in_rank_id[AW-1:0];
  assign old_val  = rd_vld_r ? rd_data_r : '0;
  assign cost_ext = TOT_W'(cost_r);
  assign sum_raw  = {1'b0, old_val} + {1'b0, cost_ext};
  assign sum_sat  = sum_raw[TOT_W] ? {TOT_W{1'b1}} : sum_raw[TOT_W-1:0];
  assign headroom = ~old_val;
  assign bad      = ({1'b0, rank_r} >= n_r);
  assign gsum     = {1'b0, grand_r} + {1'b0, GT_W'(delta_r)};
  assign emit_last = (CNT_W'(k_r) == (n_r - CNT_W'(1)));

  // rank total storage
  always_ff @(posedge clk) begin
    if (cmd.upd && !bad) begin
      mem[rank_r[AW-1:0]] <= sum_sat;
    end
    if (cmd.accept || cmd.emit_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r       <= CNT_W'(RANK_LIMIT);
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      grand_r   <= '0;
      largest_r <= '0;
      flag_r    <= 1'b0;
      k_r       <= '0;
      last_r    <= 1'b0;
    end else begin
      if (cmd.accept || cmd.emit_rd) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (cmd.accept) begin
        last_r <= in_last_block;
      end
      if (cmd.upd) begin
        if (bad) begin
          flag_r <= 1'b1;
        end else begin
          vld_r[rank_r[AW-1:0]] <= 1'b1;
          if (sum_sat > largest_r) begin
            largest_r <= sum_sat;
          end
        end
      end
      if (cmd.gadd) begin
        grand_r <= gsum[GT_W] ? {GT_W{1'b1}} : gsum[GT_W-1:0];
      end
      if (cmd.emit_next) begin
        k_r <= k_r + 1'b1;
      end
      if (cfg_wr_en) begin
        n_r <= n_nxt;
      end
      if (cfg_wr_en || cmd.clear) begin
        vld_r     <= '0;
        grand_r   <= '0;
        largest_r <= '0;
        flag_r    <= 1'b0;
        k_r       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cost_r <= in_block_cost;
      rank_r <= in_rank_id;
    end
    if (cmd.upd) begin
      if (bad) begin
        delta_r <= '0;
      end else begin
        delta_r <= (cost_ext > headroom) ? headroom : cost_ext;
      end
    end
  end

  prls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (grand_r),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_idx_r  <= RANK_W'(k_r);
      out_time_r <= old_val;
      out_max_r  <= largest_r;
      out_avg_r  <= quotient[TOT_W-1:0];
      out_bad_r  <= flag_r;
      out_last_r <= emit_last;
    end
  end

  assign stat.last_item = last_r;
  assign stat.div_done  = div_done;
  assign stat.out_taken = out_valid_r && !out_stall;
  assign stat.emit_last = emit_last;

  assign out_valid         = out_valid_r;
  assign out_rank_index    = out_idx_r;
  assign out_rank_time     = out_time_r;
  assign out_max_time      = out_max_r;
  assign out_average_time  = out_avg_r;
  assign out_bad_rank_seen = out_bad_r;
  assign out_last_result   = out_last_r;

endmodule

### hw/rtl/prls_ctrl.sv
// Controller state machine: accumulate, divide, then step through the ranks.
`timescale 1ns / 1ps
module prls_ctrl
  import prls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output prls_cmd_t  cmd,
  input  prls_stat_t stat
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UPD    = 8'b0000_0010,
    S_GADD   = 8'b0000_0100,
    S_DSTART = 8'b0000_1000,
    S_DWAIT  = 8'b0001_0000,
    S_ERD    = 8'b0010_0000,
    S_EOUT   = 8'b0100_0000,
    S_EWAIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_GADD;
      end
      S_GADD: begin
        cmd.gadd  = 1'b1;
        state_nxt = stat.last_item ? S_DSTART : S_IDLE;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EOUT;
      end
      S_EOUT: begin
        cmd.emit_load = 1'b1;
        state_nxt     = S_EWAIT;
      end
      S_EWAIT: begin
        if (stat.out_taken) begin
          if (stat.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE) || !rst_n;

endmodule

### hw/rtl/per_rank_load_summary.sv
// Top level of the per-rank load summary: controller plus datapath.
//
//   port group | direction | contents
//   in_*       | in        | block_cost, rank_id, last_block; valid/stall
//   out_*      | out       | one result per rank after a last item; valid/stall
//   cfg_*      | in        | rank_count write, no read-back
//
// Each item runs through accept, memory read-modify-write and total add in turn,
// a sequence set by the single-port rank total memory with registered read.
// A last item then starts the bit-serial division of the grand total, followed
// for each result by a memory read, a load and the hand-off.
// Reset is synchronous; rank totals are tracked by per-entry valid bits, so no
// clearing pass is needed. in_stall is high in reset and while an item or
// result run is open.
`timescale 1ns / 1ps
module per_rank_load_summary
  import prls_pkg::*;
#(
  parameter int MAX_RANKS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [COST_W-1:0] in_block_cost,
  input  logic [RANK_W-1:0] in_rank_id,
  input  logic              in_last_block,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RANK_W-1:0] out_rank_index,
  output logic [TOT_W-1:0]  out_rank_time,
  output logic [TOT_W-1:0]  out_max_time,
  output logic [TOT_W-1:0]  out_average_time,
  output logic              out_bad_rank_seen,
  output logic              out_last_result
);

  prls_cmd_t  cmd;
  prls_stat_t stat;

  prls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  prls_dp #(
    .MAX_RANKS (MAX_RANKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_block_cost     (in_block_cost),
    .in_rank_id        (in_rank_id),
    .in_last_block     (in_last_block),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rank_index    (out_rank_index),
    .out_rank_time     (out_rank_time),
    .out_max_time      (out_max_time),
    .out_average_time  (out_average_time),
    .out_bad_rank_seen (out_bad_rank_seen),
    .out_last_result   (out_last_result)
  );

endmodule

### hw/rtl/prls_chk.sv
// Port-level assertion checker for the per-rank load summary, with its bind.
`timescale 1ns / 1ps
`include "per_rank_load_summary_macros.svh"
module prls_chk
  import prls_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [RANK_W-1:0] out_rank_index,
  input logic [TOT_W-1:0]  out_rank_time,
  input logic [TOT_W-1:0]  out_max_time,
  input logic [TOT_W-1:0]  out_average_time
);

  `PRLS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_rank_index) && $stable(out_rank_time), "stalled item changed")
  `PRLS_ASSERT_NOW(a_busy_on_out, out_valid, in_stall, "input open while result pending")
  `PRLS_ASSERT_NEXT(a_no_early_out, in_valid && !in_stall, !out_valid, "result right after item")
  `PRLS_ASSERT_NOW(a_max_bound, out_valid, (out_rank_time <= out_max_time) && (out_average_time <= out_max_time), "total or average above max")

endmodule

bind per_rank_load_summary prls_chk u_chk (.*);
